[hdl/keyframe_track_interpolator_assert.svh]
// Assertion macros for the keyframe track interpolator.
`ifndef KEYFRAME_TRACK_INTERPOLATOR_ASSERT_SVH
`define KEYFRAME_TRACK_INTERPOLATOR_ASSERT_SVH
`ifndef SYNTH
`define KTI_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define KTI_ASSERT_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define KTI_ASSERT(label, clk, rst_n, prop, msg)
`define KTI_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

[hdl/kti_pkg.sv]
package kti_pkg;

  localparam int unsigned MaxFramesDef = 16;
  localparam logic [31:0] OneQ16 = 32'h0001_0000;
  localparam logic [63:0] IdQuat = 64'h4000_0000_0000_0000;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_START  = 2'd1,
    OP_STOP   = 2'd2,
    OP_UPDATE = 2'd3
  } op_e;

  typedef enum logic [0:0] {
    CFG_LOOP  = 1'b0,
    CFG_COUNT = 1'b1
  } cfg_e;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [3:0]  frame_index;
    logic [30:0] key_length;
    logic [31:0] in_trans_x;
    logic [31:0] in_trans_y;
    logic [31:0] in_trans_z;
    logic [31:0] in_scale_x;
    logic [31:0] in_scale_y;
    logic [31:0] in_scale_z;
    logic [63:0] in_rotation;
    logic [31:0] time_now;
  } in_beat_t;

  typedef struct packed {
    logic [31:0] out_trans_x;
    logic [31:0] out_trans_y;
    logic [31:0] out_trans_z;
    logic [31:0] out_scale_x;
    logic [31:0] out_scale_y;
    logic [31:0] out_scale_z;
    logic [63:0] out_rotation;
    logic [3:0]  out_frame;
  } out_beat_t;

  // One keyframe as stored in memory: duration, end time, pose.
  typedef struct packed {
    logic [31:0] dur;
    logic [31:0] kend;
    logic [31:0] tx;
    logic [31:0] ty;
    logic [31:0] tz;
    logic [31:0] sx;
    logic [31:0] sy;
    logic [31:0] sz;
    logic [63:0] rot;
  } key_t;

  // Request from the sequencer to the divider.
  typedef struct packed {
    logic        start;
    logic [47:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        busy;
    logic        done;
    logic [47:0] quot;
    logic [31:0] rem;
  } div_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LD_RD,
    ST_LD_WR,
    ST_UP_TOT,
    ST_UP_CHK,
    ST_UP_MOD,
    ST_UP_SRCH,
    ST_UP_CMP,
    ST_UP_PREV,
    ST_UP_PDIV,
    ST_UP_MUL,
    ST_UP_SUM,
    ST_OUT
  } state_e;

endpackage

[hdl/kti_key_mem.sv]
module kti_key_mem
  import kti_pkg::*;
#(
  parameter int unsigned MaxFrames = MaxFramesDef,
  localparam int unsigned AW = (MaxFrames > 1) ? $clog2(MaxFrames) : 1
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  key_t          wdata_i,
  input  logic [AW-1:0] raddr_i,
  output key_t          rdata_o
);

  key_t mem [MaxFrames];
  key_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/kti_div.sv]
// Restoring divider, one quotient bit per cycle.
module kti_div
  import kti_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;
  logic [47:0] quot_q, quot_d;
  logic [32:0] rem_q, rem_d;
  logic [31:0] dvs_q, dvs_d;
  logic [32:0] trial;

  always_comb begin
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    quot_d = quot_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    trial  = {rem_q[31:0], quot_q[47]};
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = 6'd48;
      quot_d = req_i.dividend;
      rem_d  = '0;
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      quot_d = {quot_q[46:0], 1'b0};
      if (trial >= {1'b0, dvs_q}) begin
        rem_d     = trial - {1'b0, dvs_q};
        quot_d[0] = 1'b1;
      end else begin
        rem_d = trial;
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quot = quot_q;
  assign rsp_o.rem  = rem_q[31:0];

endmodule

[hdl/keyframe_track_interpolator.sv]
// Keyframe track interpolator. Each input beat carries an opcode: load a
// keyframe slot, start the clock, stop it, or update the pose at time_now.
// Every beat gives exactly one output beat with the held pose. Keyframes live
// in one synchronous memory; a load reads the previous slot to chain the end
// time. An update runs a sequencer over that memory: one read for the total,
// an optional modulo for looping, a linear search of up to frame_count end
// times (a read and a compare a slot), a division for the progress unless
// the duration is zero, and a multiply-and-sum blend; the modulo and the
// division share the bit-serial divider, and all reads share the single
// memory read port. An update cut short (negative elapsed time, past the end,
// zero total) skips the search and the division; start, stop and an update
// while stopped go straight to the output step. The result moves into its
// own output register, so the next beat is taken as soon as the sequencer is
// idle; the sequencer holds in its output step only while that register is
// still full and stalled.
module keyframe_track_interpolator
  import kti_pkg::*;
#(
  parameter int unsigned MaxFrames = MaxFramesDef,
  localparam int unsigned AW = (MaxFrames > 1) ? $clog2(MaxFrames) : 1
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_beat_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_beat_t out_data_o,
  input  logic      cfg_we_i,
  input  logic      cfg_index_i,
  input  logic [4:0] cfg_data_i
);

  `include "keyframe_track_interpolator_assert.svh"

  localparam int unsigned CW = $clog2(MaxFrames + 1);

  state_e      state_q, state_d;
  in_beat_t    cmd_q, cmd_d;
  logic        loop_q;
  logic [4:0]  count_q;
  logic        run_q, run_d;
  logic [31:0] begin_q, begin_d;
  out_beat_t   hold_q, hold_d;
  out_beat_t   out_q, out_d;
  logic        ovalid_q, ovalid_d;
  logic [32:0] t_q, t_d;
  logic [CW-1:0] k_q, k_d;
  logic [CW-1:0] n_eff;
  key_t        cur_q, cur_d;
  logic [31:0] p_q, p_d;
  logic signed [63:0] prod_q [12];
  logic signed [63:0] prod_d [12];

  logic          we;
  logic [AW-1:0] waddr, raddr;
  key_t          wdata, rdata;
  div_req_t      dreq;
  div_rsp_t      drsp;

  kti_key_mem #(.MaxFrames(MaxFrames)) u_mem (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  kti_div u_div (.clk_i, .rst_ni, .req_i(dreq), .rsp_o(drsp));

  // Clamp frame_count to 1..MaxFrames.
  always_comb begin
    if (count_q == 5'd0) begin
      n_eff = CW'(1);
    end else if (32'(count_q) > 32'(MaxFrames)) begin
      n_eff = CW'(MaxFrames);
    end else begin
      n_eff = CW'(count_q);
    end
  end

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loop_q  <= 1'b0;
      count_q <= 5'd1;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_LOOP:  loop_q  <= cfg_data_i[0];
        CFG_COUNT: count_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [32:0] end_sum;
  logic signed [33:0] ft;
  logic [31:0] ftc;
  logic [31:0] prv [6];
  logic [31:0] cv [6];
  logic signed [33:0] sum [6];
  logic [31:0] res [6];

  always_comb begin
    cv[0] = cur_q.tx; cv[1] = cur_q.ty; cv[2] = cur_q.tz;
    cv[3] = cur_q.sx; cv[4] = cur_q.sy; cv[5] = cur_q.sz;
    if (k_q == '0) begin
      for (int i = 0; i < 3; i++) begin
        prv[i]   = '0;
        prv[i+3] = OneQ16;
      end
    end else begin
      prv[0] = rdata.tx; prv[1] = rdata.ty; prv[2] = rdata.tz;
      prv[3] = rdata.sx; prv[4] = rdata.sy; prv[5] = rdata.sz;
    end
    for (int i = 0; i < 6; i++) begin
      sum[i] = 34'((prod_q[2*i] + prod_q[2*i+1] + 64'sd32768) >>> 16);
      res[i] = sum[i][31:0];
    end
    end_sum = {1'b0, rdata.kend} + {2'b0, cmd_q.key_length};
    ft = $signed({1'b0, t_q}) - ($signed({2'b0, cur_q.kend}) - $signed({2'b0, cur_q.dur}));
  end

  always_comb begin
    if (ft < 0) begin
      ftc = '0;
    end else if (ft > $signed({2'b0, cur_q.dur})) begin
      ftc = cur_q.dur;
    end else begin
      ftc = ft[31:0];
    end
  end

  always_comb begin
    logic signed [33:0] el;
    state_d  = state_q;
    cmd_d    = cmd_q;
    run_d    = run_q;
    begin_d  = begin_q;
    hold_d   = hold_q;
    out_d    = out_q;
    ovalid_d = ovalid_q;
    t_d      = t_q;
    k_d      = k_q;
    cur_d    = cur_q;
    p_d      = p_q;
    prod_d   = prod_q;
    we       = 1'b0;
    waddr    = cmd_q.frame_index[AW-1:0];
    wdata    = '0;
    raddr    = k_q[AW-1:0];
    dreq     = '0;
    in_stall_o = (state_q != ST_IDLE);
    el = $signed({{2{cmd_q.time_now[31]}}, cmd_q.time_now})
       - $signed({{2{begin_q[31]}}, begin_q});
    if (out_valid_o && !out_stall_i) begin
      ovalid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i && !in_stall_o) begin
          cmd_d = in_data_i;
          case (op_e'(in_data_i.opcode))
            OP_LOAD: begin
              state_d = ST_LD_RD;
              if (32'(in_data_i.frame_index) >= 32'(MaxFrames)) state_d = ST_OUT;
            end
            OP_START: begin
              begin_d = in_data_i.time_now;
              run_d   = 1'b1;
              state_d = ST_OUT;
            end
            OP_STOP: begin
              run_d   = 1'b0;
              state_d = ST_OUT;
            end
            default: state_d = run_q ? ST_UP_TOT : ST_OUT;
          endcase
        end
      end
      ST_LD_RD: begin
        // Read the slot before for the running end time.
        raddr   = AW'(cmd_q.frame_index - 4'd1);
        state_d = ST_LD_WR;
      end
      ST_LD_WR: begin
        we         = 1'b1;
        wdata.dur  = {1'b0, cmd_q.key_length};
        if (cmd_q.frame_index == 4'd0) begin
          wdata.kend = {1'b0, cmd_q.key_length};
        end else begin
          wdata.kend = end_sum[32] ? 32'hFFFF_FFFF : end_sum[31:0];
        end
        wdata.tx  = cmd_q.in_trans_x;
        wdata.ty  = cmd_q.in_trans_y;
        wdata.tz  = cmd_q.in_trans_z;
        wdata.sx  = cmd_q.in_scale_x;
        wdata.sy  = cmd_q.in_scale_y;
        wdata.sz  = cmd_q.in_scale_z;
        wdata.rot = cmd_q.in_rotation;
        state_d   = ST_OUT;
      end
      ST_UP_TOT: begin
        raddr   = AW'(n_eff - CW'(1));
        state_d = ST_UP_CHK;
      end
      ST_UP_CHK: begin
        t_d = el[32:0];
        k_d = '0;
        if (el < 0) begin
          hold_d  = {32'd0, 32'd0, 32'd0, OneQ16, OneQ16, OneQ16, IdQuat, 4'd0};
          state_d = ST_OUT;
        end else if (!loop_q && ({1'b0, el[32:0]} > {2'b0, rdata.kend})) begin
          hold_d  = {rdata.tx, rdata.ty, rdata.tz, rdata.sx, rdata.sy, rdata.sz,
                     rdata.rot, 4'(n_eff - CW'(1))};
          state_d = ST_OUT;
        end else if (loop_q) begin
          if (rdata.kend == '0) begin
            hold_d  = {32'd0, 32'd0, 32'd0, OneQ16, OneQ16, OneQ16, IdQuat, 4'd0};
            state_d = ST_OUT;
          end else begin
            dreq.start    = 1'b1;
            dreq.dividend = {15'd0, el[32:0]};
            dreq.divisor  = rdata.kend;
            state_d       = ST_UP_MOD;
          end
        end else begin
          state_d = ST_UP_SRCH;
        end
      end
      ST_UP_MOD: begin
        if (drsp.done) begin
          t_d     = {1'b0, drsp.rem};
          state_d = ST_UP_SRCH;
        end
      end
      ST_UP_SRCH: begin
        // Memory read of slot k in flight.
        state_d = ST_UP_CMP;
      end
      ST_UP_CMP: begin
        if ({1'b0, rdata.kend} > t_q) begin
          cur_d   = rdata;
          raddr   = AW'(k_q - CW'(1));
          state_d = ST_UP_PREV;
        end else if (k_q + CW'(1) >= n_eff) begin
          hold_d  = {32'd0, 32'd0, 32'd0, OneQ16, OneQ16, OneQ16, IdQuat, 4'd0};
          state_d = ST_OUT;
        end else begin
          k_d     = k_q + CW'(1);
          raddr   = AW'(k_q + CW'(1));
          state_d = ST_UP_SRCH;
        end
      end
      ST_UP_PREV: begin
        // Previous slot read in flight; hold its address, start the division unless the duration is zero.
        raddr = AW'(k_q - CW'(1));
        if (cur_q.dur == '0) begin
          p_d     = OneQ16;
          state_d = ST_UP_MUL;
        end else begin
          dreq.start    = 1'b1;
          dreq.dividend = {ftc, 16'd0};
          dreq.divisor  = cur_q.dur;
          state_d       = ST_UP_PDIV;
        end
      end
      ST_UP_PDIV: begin
        raddr = AW'(k_q - CW'(1));
        if (drsp.done) begin
          p_d     = drsp.quot[31:0];
          state_d = ST_UP_MUL;
        end
      end
      ST_UP_MUL: begin
        raddr = AW'(k_q - CW'(1));
        for (int i = 0; i < 6; i++) begin
          prod_d[2*i]   = $signed(cv[i]) * $signed({32'd0, p_q});
          prod_d[2*i+1] = $signed(prv[i]) * $signed({32'd0, OneQ16 - p_q});
        end
        state_d = ST_UP_SUM;
      end
      ST_UP_SUM: begin
        hold_d  = {res[0], res[1], res[2], res[3], res[4], res[5], cur_q.rot,
                   4'(k_q)};
        state_d = ST_OUT;
      end
      ST_OUT: begin
        // Hold here while the output register still waits on a stalled beat.
        if (!ovalid_q || !out_stall_i) begin
          out_d    = hold_q;
          ovalid_d = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      run_q    <= 1'b0;
      begin_q  <= '0;
      ovalid_q <= 1'b0;
      hold_q   <= {32'd0, 32'd0, 32'd0, OneQ16, OneQ16, OneQ16, IdQuat, 4'd0};
      out_q    <= {32'd0, 32'd0, 32'd0, OneQ16, OneQ16, OneQ16, IdQuat, 4'd0};
    end else begin
      state_q  <= state_d;
      run_q    <= run_d;
      begin_q  <= begin_d;
      ovalid_q <= ovalid_d;
      hold_q   <= hold_d;
      out_q    <= out_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    t_q    <= t_d;
    k_q    <= k_d;
    cur_q  <= cur_d;
    p_q    <= p_d;
    prod_q <= prod_d;
  end

  assign out_valid_o = ovalid_q;
  assign out_data_o  = out_q;

  `KTI_ASSERT(a_no_accept_busy, clk_i, rst_ni, (state_q != ST_IDLE) |-> in_stall_o, "beat taken while busy")
  `KTI_ASSERT(a_out_from_seq, clk_i, rst_ni, $rose(ovalid_q) |-> $past(state_q == ST_OUT), "output without sequencer")
  `KTI_ASSERT(a_div_idle, clk_i, rst_ni, dreq.start |-> !drsp.busy, "divider restarted while busy")
  `KTI_ASSERT(a_prog_range, clk_i, rst_ni, (state_q == ST_UP_MUL) |-> (p_q <= OneQ16), "progress out of range")

endmodule

[test/tb.sv]
`timescale 1ns / 100ps

module tb;
  import kti_pkg::*;

  localparam int unsigned SlotCount  = 16;
  localparam int unsigned IdleLimit  = 5000;
  localparam int unsigned HoldOffLen = 400;
  localparam int unsigned DrainWait  = 200;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_beat_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_beat_t out_data;
  logic      cfg_we = 1'b0;
  logic      cfg_index = 1'b0;
  logic [4:0] cfg_data = '0;

  keyframe_track_interpolator dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always #5 clk = ~clk;

  // Track model: keyframe store, clock state, held pose and registers
  logic [31:0]        trk_dur [SlotCount];
  logic [31:0]        trk_end [SlotCount];
  logic signed [31:0] trk_tx [SlotCount];
  logic signed [31:0] trk_ty [SlotCount];
  logic signed [31:0] trk_tz [SlotCount];
  logic signed [31:0] trk_sx [SlotCount];
  logic signed [31:0] trk_sy [SlotCount];
  logic signed [31:0] trk_sz [SlotCount];
  logic [63:0]        trk_rot [SlotCount];
  logic               clock_running = 1'b0;
  logic signed [31:0] clock_origin = '0;
  out_beat_t          held_pose;
  logic               loop_on = 1'b0;
  logic [4:0]         frames_used = 5'd1;

  out_beat_t pending_poses[$];
  int unsigned mismatches = 0;

  // Sender burst shaping and receiver hold-off request
  int unsigned burst_left = 0;
  bit          hold_off_req = 1'b0;
  int unsigned hold_left = 0;
  int unsigned stall_mode = 0;
  int unsigned stall_left = 0;

  function automatic out_beat_t identity_pose();
    out_beat_t p;
    p.out_trans_x  = '0;
    p.out_trans_y  = '0;
    p.out_trans_z  = '0;
    p.out_scale_x  = OneQ16;
    p.out_scale_y  = OneQ16;
    p.out_scale_z  = OneQ16;
    p.out_rotation = IdQuat;
    p.out_frame    = '0;
    return p;
  endfunction

  // Rounded half up: floor((cur*p + prev*(1-p) + half) / one)
  function automatic logic [31:0] lerp_q16(logic signed [31:0] prev,
                                           logic signed [31:0] cur, longint p);
    longint s;
    s = longint'(cur) * p + longint'(prev) * (64'sd65536 - p);
    s = (s + 64'sd32768) >>> 16;
    return s[31:0];
  endfunction

  function automatic int unsigned used_frames();
    int unsigned n;
    n = frames_used;
    if (n < 1) n = 1;
    if (n > SlotCount) n = SlotCount;
    return n;
  endfunction

  function automatic void advance_pose(logic signed [31:0] now);
    int unsigned n, k;
    longint e, total, t, seg_start, ft, p;
    logic signed [31:0] pt [3];
    logic signed [31:0] ps [3];
    bit found;
    found = 1'b0;
    n = used_frames();
    e = longint'(now) - longint'(clock_origin);
    if (e < 0) begin
      held_pose = identity_pose();
      return;
    end
    total = longint'({32'd0, trk_end[n-1]});
    if (!loop_on && e > total) begin
      k = n - 1;
      held_pose.out_trans_x  = trk_tx[k];
      held_pose.out_trans_y  = trk_ty[k];
      held_pose.out_trans_z  = trk_tz[k];
      held_pose.out_scale_x  = trk_sx[k];
      held_pose.out_scale_y  = trk_sy[k];
      held_pose.out_scale_z  = trk_sz[k];
      held_pose.out_rotation = trk_rot[k];
      held_pose.out_frame    = k[3:0];
      return;
    end
    t = e;
    if (loop_on) begin
      if (total == 0) begin
        held_pose = identity_pose();
        return;
      end
      t = t % total;
    end
    for (k = 0; k < n; k++) begin
      if (longint'({32'd0, trk_end[k]}) > t) begin
        found = 1'b1;
        break;
      end
    end
    if (!found) begin
      held_pose = identity_pose();
      return;
    end
    if (trk_dur[k] == 0) begin
      p = 65536;
    end else begin
      seg_start = longint'({32'd0, trk_end[k]}) - longint'({32'd0, trk_dur[k]});
      ft = t - seg_start;
      if (ft < 0) ft = 0;
      if (ft > longint'({32'd0, trk_dur[k]})) ft = longint'({32'd0, trk_dur[k]});
      p = (ft << 16) / longint'({32'd0, trk_dur[k]});
    end
    if (k == 0) begin
      pt = '{32'sd0, 32'sd0, 32'sd0};
      ps = '{32'sd65536, 32'sd65536, 32'sd65536};
    end else begin
      pt = '{trk_tx[k-1], trk_ty[k-1], trk_tz[k-1]};
      ps = '{trk_sx[k-1], trk_sy[k-1], trk_sz[k-1]};
    end
    held_pose.out_trans_x  = lerp_q16(pt[0], trk_tx[k], p);
    held_pose.out_trans_y  = lerp_q16(pt[1], trk_ty[k], p);
    held_pose.out_trans_z  = lerp_q16(pt[2], trk_tz[k], p);
    held_pose.out_scale_x  = lerp_q16(ps[0], trk_sx[k], p);
    held_pose.out_scale_y  = lerp_q16(ps[1], trk_sy[k], p);
    held_pose.out_scale_z  = lerp_q16(ps[2], trk_sz[k], p);
    held_pose.out_rotation = trk_rot[k];
    held_pose.out_frame    = k[3:0];
  endfunction

  function automatic out_beat_t pose_after(in_beat_t b);
    int unsigned idx;
    logic [32:0] chained;
    case (op_e'(b.opcode))
      OP_LOAD: begin
        idx = b.frame_index;
        chained = (idx == 0) ? 33'd0 : {1'b0, trk_end[idx-1]};
        chained = chained + {2'b00, b.key_length};
        trk_dur[idx] = {1'b0, b.key_length};
        trk_end[idx] = chained[32] ? 32'hFFFF_FFFF : chained[31:0];
        trk_tx[idx]  = b.in_trans_x;
        trk_ty[idx]  = b.in_trans_y;
        trk_tz[idx]  = b.in_trans_z;
        trk_sx[idx]  = b.in_scale_x;
        trk_sy[idx]  = b.in_scale_y;
        trk_sz[idx]  = b.in_scale_z;
        trk_rot[idx] = b.in_rotation;
      end
      OP_START: begin
        clock_origin  = b.time_now;
        clock_running = 1'b1;
      end
      OP_STOP: clock_running = 1'b0;
      default: if (clock_running) advance_pose(b.time_now);
    endcase
    return held_pose;
  endfunction

  // Offer one beat, honouring the burst/gap pattern, and log its pose on acceptance
  task automatic send_beat(in_beat_t b);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= b;
    do @(posedge clk); while (!(in_valid && !in_stall));
    pending_poses.push_back(pose_after(b));
  endtask

  // Drop valid and hold until every pose has come back
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_poses.size() != 0) @(posedge clk);
  endtask

  task automatic cfg_write(cfg_e idx, logic [4:0] val);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_LOOP) loop_on = val[0];
    else frames_used = val;
  endtask

  function automatic in_beat_t make_beat(op_e op);
    in_beat_t b;
    b = '0;
    b.opcode      = op;
    b.frame_index = $urandom_range(0, 15);
    b.key_length  = $urandom;
    b.in_trans_x  = $urandom;
    b.in_trans_y  = $urandom;
    b.in_trans_z  = $urandom;
    b.in_scale_x  = $urandom;
    b.in_scale_y  = $urandom;
    b.in_scale_z  = $urandom;
    b.in_rotation = {$urandom, $urandom};
    b.time_now    = $urandom;
    return b;
  endfunction

  function automatic in_beat_t key_beat(int unsigned slot, logic [30:0] len,
                                        logic [31:0] tv, logic [31:0] sv,
                                        logic [63:0] rot);
    in_beat_t b;
    b = make_beat(OP_LOAD);
    b.frame_index = slot;
    b.key_length  = len;
    b.in_trans_x  = tv;
    b.in_trans_y  = -tv;
    b.in_trans_z  = tv ^ 32'h5A5A_5A5A;
    b.in_scale_x  = sv;
    b.in_scale_y  = ~sv;
    b.in_scale_z  = sv + 32'h0001_0000;
    b.in_rotation = rot;
    return b;
  endfunction

  function automatic in_beat_t timed_beat(op_e op, logic [31:0] t);
    in_beat_t b;
    b = make_beat(op);
    b.time_now = t;
    return b;
  endfunction

  // Random beat with content aimed around the current track timeline
  function automatic in_beat_t random_beat();
    in_beat_t b;
    int unsigned pick;
    longint total;
    pick = $urandom_range(0, 99);
    total = longint'({32'd0, trk_end[used_frames()-1]});
    if (pick < 20) begin
      b = make_beat(OP_LOAD);
      case ($urandom_range(0, 9))
        0: b.key_length = 31'h7FFF_FFFF;
        1: if (b.key_length == 0) b.key_length = 31'd1;
        default: b.key_length = $urandom_range(1, 32'h0003_0000);
      endcase
      if ($urandom_range(0, 1)) begin
        b.in_trans_x = $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
        b.in_scale_x = $urandom_range(0, 32'h0004_0000);
      end
    end else if (pick < 30) begin
      b = make_beat(OP_START);
      if ($urandom_range(0, 1)) b.time_now = $urandom_range(0, 32'h0010_0000);
    end else if (pick < 34) begin
      b = make_beat(OP_STOP);
    end else begin
      b = make_beat(OP_UPDATE);
      case ($urandom_range(0, 9))
        0: ;
        1: b.time_now = clock_origin - $signed($urandom_range(1, 100000));
        2: b.time_now = clock_origin + total[31:0];
        3: b.time_now = clock_origin + total[31:0] + $urandom_range(1, 100000);
        default: b.time_now = clock_origin +
                   $urandom_range(0, (total > 32'hFFFF_FFFF) ? 32'hFFFF_FFFF : total[31:0]);
      endcase
    end
    return b;
  endfunction

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
    end
  endtask

  // Compare each output beat with the oldest pose waiting
  always @(posedge clk) begin
    out_beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_poses.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected output beat: expected none, actual %h", $time, out_data);
      end else begin
        want = pending_poses.pop_front();
        check_field("out_trans_x", want.out_trans_x, out_data.out_trans_x);
        check_field("out_trans_y", want.out_trans_y, out_data.out_trans_y);
        check_field("out_trans_z", want.out_trans_z, out_data.out_trans_z);
        check_field("out_scale_x", want.out_scale_x, out_data.out_scale_x);
        check_field("out_scale_y", want.out_scale_y, out_data.out_scale_y);
        check_field("out_scale_z", want.out_scale_z, out_data.out_scale_z);
        check_field("out_rotation", want.out_rotation, out_data.out_rotation);
        check_field("out_frame", want.out_frame, out_data.out_frame);
      end
    end
  end

  // Receiver stall: long hold-off on request, otherwise a shifting pattern
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (hold_off_req) begin
      hold_off_req = 1'b0;
      hold_left = HoldOffLen;
      out_stall <= 1'b1;
    end else begin
      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 2);
        stall_left = $urandom_range(20, 200);
      end
      stall_left--;
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        default: out_stall <= $urandom_range(0, 1);
      endcase
    end
  end

  // Watchdog: end the run after too long without any beat moving
  int unsigned quiet_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= IdleLimit) begin
      $display("keyframe_track_interpolator regression: fail");
      $finish;
    end
  end

  // Fill every slot in order so no update or chained end time ever uses an empty slot
  task automatic test_load_track();
    cfg_write(CFG_LOOP, 1'b0);
    cfg_write(CFG_COUNT, 5'd16);
    send_beat(key_beat(0, 31'd1, 32'h7FFF_FFFF, 32'h8000_0000, 64'hFFFF_FFFF_FFFF_FFFF));
    send_beat(key_beat(1, 31'h0001_0000, 32'h8000_0000, 32'h7FFF_FFFF, 64'd0));
    for (int unsigned s = 2; s < 14; s++)
      send_beat(key_beat(s, $urandom_range(1, 32'h0002_0000), $urandom, $urandom,
                         {$urandom, $urandom}));
    // Two maximal durations push the chained end time into saturation
    send_beat(key_beat(14, 31'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, IdQuat));
    send_beat(key_beat(15, 31'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000, {$urandom, $urandom}));
  endtask

  task automatic test_clock_ops();
    send_beat(timed_beat(OP_UPDATE, 32'h0000_1000));           // stopped: ignored
    send_beat(timed_beat(OP_START, 32'h8000_0000));
    send_beat(timed_beat(OP_UPDATE, 32'h7FFF_FFFF));           // wraps to a large elapsed
    send_beat(timed_beat(OP_START, 32'h0001_0000));            // restart while running
    send_beat(timed_beat(OP_UPDATE, 32'h0000_0000));           // negative elapsed
    send_beat(timed_beat(OP_UPDATE, 32'h0001_8000));           // inside second keyframe
    send_beat(timed_beat(OP_UPDATE, 32'h0001_0001));           // first keyframe end
    send_beat(timed_beat(OP_STOP, 32'h0));
    send_beat(timed_beat(OP_UPDATE, 32'h0002_0000));           // stopped again
  endtask

  task automatic test_register_extremes();
    send_beat(timed_beat(OP_START, 32'h0));
    cfg_write(CFG_COUNT, 5'd2);
    send_beat(timed_beat(OP_UPDATE, 32'h0001_0001));           // exactly at the end
    send_beat(timed_beat(OP_UPDATE, 32'h0003_0000));           // past the end, held
    cfg_write(CFG_LOOP, 1'b1);
    send_beat(timed_beat(OP_UPDATE, 32'h0003_0000));           // wrapped
    cfg_write(CFG_COUNT, 5'd0);
    send_beat(timed_beat(OP_UPDATE, 32'h0000_0000));
    cfg_write(CFG_COUNT, 5'd31);
    send_beat(timed_beat(OP_UPDATE, 32'h7FFF_FFFF));
    cfg_write(CFG_LOOP, 1'b0);
    send_beat(timed_beat(OP_UPDATE, 32'h7FFF_FFFF));
  endtask

  // Hold the receiver off while the sender keeps offering, then pause for a full drain
  task automatic test_backpressure();
    hold_off_req = 1'b1;
    repeat (12) send_beat(random_beat());
    drain();
  endtask

  task automatic test_random_track(int unsigned beats, bit lp, logic [4:0] cnt);
    cfg_write(CFG_LOOP, lp);
    cfg_write(CFG_COUNT, cnt);
    send_beat(timed_beat(OP_START, $urandom));
    repeat (beats) send_beat(random_beat());
  endtask

  initial begin
    held_pose = identity_pose();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_load_track();
    test_clock_ops();
    test_register_extremes();
    test_random_track(400, 1'b0, 5'd16);
    test_backpressure();
    test_random_track(350, 1'b1, 5'd5);
    test_random_track(250, 1'b0, 5'd1);
    test_random_track(350, 1'b1, 5'd16);
    test_backpressure();
    test_random_track(150, 1'b0, 5'd9);
    drain();
    repeat (DrainWait) @(posedge clk);
    if (mismatches == 0) begin
      $display("keyframe_track_interpolator regression: pass");
    end else begin
      $display("keyframe_track_interpolator regression: fail");
    end
    $finish;
  end

endmodule
